### design/nearest_labeled_cell_search_defines.svh
// ----------------------------------------------------------------------------
// Nearest labeled cell search: assertion macros
// Shorthand for the concurrent checks used by the block's checker.
// ----------------------------------------------------------------------------
`ifndef NEAREST_LABELED_CELL_SEARCH_DEFINES_SVH
`define NEAREST_LABELED_CELL_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define NLCS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nlcs: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define NLCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nlcs: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define NLCS_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("nlcs: reset check failed");

`endif

### design/nlcs_pkg.sv
// ----------------------------------------------------------------------------
// Nearest labeled cell search: package
// Shared constants, register indexes, request codes, state type and coordinate struct.
// ----------------------------------------------------------------------------
`default_nettype none

package nlcs_pkg;

  localparam int MAX_ROWS_DEF   = 256;
  localparam int MAX_COLS_DEF   = 256;
  localparam int LABEL_BITS_DEF = 8;

  localparam int CELL_IDX_W  = 8;
  localparam int LABEL_FLD_W = 8;
  localparam int POINT_W     = 32;
  localparam int DIM_W       = 9;
  localparam int EDGE_W      = 24;

  localparam int COORD_W = 42;
  localparam int SQ_IN_W = 32;
  localparam int DIST_W  = 64;

  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CELL_EDGE   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = CFG_IDX_W'(4);

  localparam logic [DIM_W-1:0]  ROWS_RST = DIM_W'(256);
  localparam logic [DIM_W-1:0]  COLS_RST = DIM_W'(256);
  localparam logic [EDGE_W-1:0] EDGE_RST = EDGE_W'(16);

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_START,
    ST_BOUND,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } coord_t;

endpackage

`default_nettype wire

### design/nlcs_req_if.sv
// ----------------------------------------------------------------------------
// Nearest labeled cell search: request channel
// Carries cell writes and point queries into the block.
// ----------------------------------------------------------------------------
`default_nettype none

interface nlcs_req_if;
  import nlcs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [CELL_IDX_W-1:0]     cell_row;
  logic [CELL_IDX_W-1:0]     cell_col;
  logic [LABEL_FLD_W-1:0]    cell_label;
  logic signed [POINT_W-1:0] point_x;
  logic signed [POINT_W-1:0] point_y;

  modport source (
    output valid, req_type, cell_row, cell_col, cell_label, point_x, point_y,
    input  ready
  );

  modport sink (
    input  valid, req_type, cell_row, cell_col, cell_label, point_x, point_y,
    output ready
  );

endinterface

`default_nettype wire

### design/nlcs_res_if.sv
// ----------------------------------------------------------------------------
// Nearest labeled cell search: result channel
// Carries one query result out of the block.
// ----------------------------------------------------------------------------
`default_nettype none

interface nlcs_res_if;
  import nlcs_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [LABEL_FLD_W-1:0] nearest_label;
  logic                   found;

  modport source (
    output valid, nearest_label, found,
    input  ready
  );

  modport sink (
    input  valid, nearest_label, found,
    output ready
  );

endinterface

`default_nettype wire

### design/nearest_labeled_cell_search.sv
// ----------------------------------------------------------------------------
// Nearest labeled cell search: top level
// Label raster in a single RAM, scanned once per query for the nearest
// labeled cell center.
// ----------------------------------------------------------------------------
// After reset the block clears the label RAM, one entry per cycle, over all
// MAX_ROWS * 2**ceil(log2(MAX_COLS)) entries (65536 at the default size); no
// request transfer is accepted during that pass, while register writes are.
// A cell write goes into the RAM as it is transferred. A query passes through
// the setup, start and bound states, then scans R * C cells, where R and C are
// rows_in_use and cols_in_use capped at MAX_ROWS and MAX_COLS, and goes from
// setup straight to drain when either is zero: the RAM read port delivers one
// cell per cycle to the distance pipeline, and the drain state waits for that
// pipeline to empty before the result is loaded. A result still waiting from
// the previous query delays the load. The next request is taken from the cycle
// after the load. The result waits in an output register, and the next request can be accepted while it does.
`default_nettype none

module nearest_labeled_cell_search #(
  parameter int MAX_ROWS   = nlcs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = nlcs_pkg::MAX_COLS_DEF,
  parameter int LABEL_BITS = nlcs_pkg::LABEL_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  nlcs_req_if.sink                     req,
  nlcs_res_if.source                   res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nlcs_pkg::PADDR_W-1:0] paddr,
  input  logic [nlcs_pkg::PDATA_W-1:0] pwdata,
  output logic [nlcs_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import nlcs_pkg::*;

  localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DEPTH   = MAX_ROWS * (2 ** COL_W);
  localparam int RAM_AW  = $clog2(DEPTH);
  localparam int NR_W    = $clog2(MAX_ROWS + 1);
  localparam int NC_W    = $clog2(MAX_COLS + 1);
  localparam int SUM_W   = $clog2(MAX_ROWS + MAX_COLS + 1);
  localparam int EXT_R_W = (ROW_W > CELL_IDX_W) ? ROW_W : CELL_IDX_W;
  localparam int EXT_C_W = (COL_W > CELL_IDX_W) ? COL_W : CELL_IDX_W;

  function automatic logic signed [COORD_W-1:0] coord_dbl(
    input logic signed [POINT_W-1:0] v
  );
    return {{(COORD_W-POINT_W-1){v[POINT_W-1]}}, v, 1'b0};
  endfunction

  state_t state;
  state_t state_next;

  logic [DIM_W-1:0]          rows_in_use;
  logic [DIM_W-1:0]          cols_in_use;
  logic [EDGE_W-1:0]         cell_edge;
  logic signed [POINT_W-1:0] origin_x;
  logic signed [POINT_W-1:0] origin_y;
  logic [CFG_IDX_W-1:0]      cfg_idx;
  logic                      cfg_wr;

  logic [NR_W-1:0]  nr;
  logic [NC_W-1:0]  nc;
  logic [SUM_W-1:0] dim_sum;

  logic [RAM_AW-1:0]     clr_addr;
  logic                  ram_we;
  logic [RAM_AW-1:0]     ram_waddr;
  logic [LABEL_BITS-1:0] ram_wdata;
  logic [RAM_AW-1:0]     ram_raddr;
  logic [LABEL_BITS-1:0] ram_rdata;

  logic [EXT_R_W-1:0] wr_row_ext;
  logic [EXT_C_W-1:0] wr_col_ext;
  logic               wr_in_range;
  logic               query_take;

  logic [ROW_W-1:0]          last_row;
  logic [COL_W-1:0]          last_col;
  logic [ROW_W-1:0]          row_idx;
  logic [COL_W-1:0]          col_idx;
  logic [COORD_W-1:0]        span_y;
  logic [COORD_W-1:0]        span_b;
  logic [COORD_W-1:0]        bound2;
  logic signed [COORD_W-1:0] edge_s;
  logic signed [COORD_W-1:0] step_s;
  logic signed [COORD_W-1:0] cx0;
  logic signed [COORD_W-1:0] cx;
  logic signed [COORD_W-1:0] cy;
  coord_t                    pt;

  logic   p0_valid;
  coord_t p0_ctr;
  coord_t cur_ctr;

  logic                  dist_valid;
  logic [LABEL_BITS-1:0] dist_label;
  logic [DIST_W-1:0]     dist_val;
  logic                  dist_busy;

  logic [DIST_W-1:0]     best;
  logic [LABEL_BITS-1:0] best_label;
  logic                  hit;

  logic                   res_valid;
  logic [LABEL_FLD_W-1:0] res_label;
  logic                   res_found;
  logic                   out_free;
  logic                   drained;
  logic                   load_result;

  // Register port.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= ROWS_RST;
      cols_in_use <= COLS_RST;
      cell_edge   <= EDGE_RST;
      origin_x    <= '0;
      origin_y    <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ROWS_IN_USE: rows_in_use <= pwdata[DIM_W-1:0];
        REG_COLS_IN_USE: cols_in_use <= pwdata[DIM_W-1:0];
        REG_CELL_EDGE:   cell_edge   <= pwdata[EDGE_W-1:0];
        REG_ORIGIN_X:    origin_x    <= $signed(pwdata[POINT_W-1:0]);
        REG_ORIGIN_Y:    origin_y    <= $signed(pwdata[POINT_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ROWS_IN_USE: prdata = PDATA_W'(rows_in_use);
      REG_COLS_IN_USE: prdata = PDATA_W'(cols_in_use);
      REG_CELL_EDGE:   prdata = PDATA_W'(cell_edge);
      REG_ORIGIN_X:    prdata = $unsigned(origin_x);
      REG_ORIGIN_Y:    prdata = $unsigned(origin_y);
      default:         prdata = '0;
    endcase
  end

  // Scan extent and geometry.
  assign nr      = (int'(rows_in_use) > MAX_ROWS) ? NR_W'(MAX_ROWS) : NR_W'(rows_in_use);
  assign nc      = (int'(cols_in_use) > MAX_COLS) ? NC_W'(MAX_COLS) : NC_W'(cols_in_use);
  assign dim_sum = SUM_W'(nr) + SUM_W'(nc);
  assign edge_s  = $signed(COORD_W'(cell_edge));
  assign step_s  = $signed(COORD_W'({cell_edge, 1'b0}));

  assign wr_row_ext  = EXT_R_W'(req.cell_row);
  assign wr_col_ext  = EXT_C_W'(req.cell_col);
  assign wr_in_range = (int'(req.cell_row) < MAX_ROWS) && (int'(req.cell_col) < MAX_COLS);

  assign cur_ctr.x = cx;
  assign cur_ctr.y = cy;
  assign ram_raddr = RAM_AW'({row_idx, col_idx});

  assign drained  = !p0_valid && !dist_busy;
  assign out_free = !res_valid || res.ready;

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == RAM_AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req.valid && req.req_type == REQ_QUERY) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (nr == '0 || nc == '0) begin
          state_next = ST_DRAIN;
        end else begin
          state_next = ST_START;
        end
      end
      ST_START: state_next = ST_BOUND;
      ST_BOUND: state_next = ST_SCAN;
      ST_SCAN: begin
        if (col_idx == last_col && row_idx == last_row) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drained && out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = clr_addr;
    ram_wdata   = '0;
    query_take  = 1'b0;
    load_result = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        req.ready  = 1'b1;
        query_take = req.valid && req.req_type == REQ_QUERY;
        ram_we     = req.valid && req.req_type == REQ_WRITE && wr_in_range;
        ram_waddr  = RAM_AW'({wr_row_ext[ROW_W-1:0], wr_col_ext[COL_W-1:0]});
        ram_wdata  = LABEL_BITS'(req.cell_label);
      end
      ST_DRAIN: begin
        load_result = drained && out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      p0_valid <= 1'b0;
    end else begin
      state    <= state_next;
      p0_valid <= (state == ST_SCAN);
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + RAM_AW'(1);
      end
    end
  end

  // Query datapath.
  always_ff @(posedge clk) begin
    p0_ctr <= cur_ctr;
    if (query_take) begin
      pt.x       <= coord_dbl(req.point_x);
      pt.y       <= coord_dbl(req.point_y);
      hit        <= 1'b0;
      best_label <= '0;
    end else if (dist_valid && dist_label != '0 && dist_val < best) begin
      best       <= dist_val;
      best_label <= dist_label;
      hit        <= 1'b1;
    end
    case (state)
      ST_SETUP: begin
        last_row <= ROW_W'(nr - NR_W'(1));
        last_col <= COL_W'(nc - NC_W'(1));
        span_y   <= COORD_W'(nr - NR_W'(1)) * COORD_W'(cell_edge);
        span_b   <= COORD_W'(dim_sum) * COORD_W'(cell_edge);
      end
      ST_START: begin
        cx0     <= coord_dbl(origin_x) + edge_s;
        cx      <= coord_dbl(origin_x) + edge_s;
        cy      <= coord_dbl(origin_y) + $signed({span_y[COORD_W-2:0], 1'b0}) + edge_s;
        bound2  <= {span_b[COORD_W-2:0], 1'b0};
        row_idx <= '0;
        col_idx <= '0;
      end
      ST_BOUND: begin
        best <= (|bound2[COORD_W-1:SQ_IN_W]) ? {DIST_W{1'b1}} :
                DIST_W'(bound2[SQ_IN_W-1:0]) * DIST_W'(bound2[SQ_IN_W-1:0]);
      end
      ST_SCAN: begin
        if (col_idx == last_col) begin
          col_idx <= '0;
          cx      <= cx0;
          row_idx <= row_idx + ROW_W'(1);
          cy      <= cy - step_s;
        end else begin
          col_idx <= col_idx + COL_W'(1);
          cx      <= cx + step_s;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_result) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      res_label <= LABEL_FLD_W'(best_label);
      res_found <= hit;
    end
  end

  assign res.valid         = res_valid;
  assign res.nearest_label = res_label;
  assign res.found         = res_found;

  nlcs_ram #(
    .WIDTH (LABEL_BITS),
    .DEPTH (DEPTH)
  ) u_label_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nlcs_dist #(
    .LABEL_BITS (LABEL_BITS)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .pt        (pt),
    .in_valid  (p0_valid),
    .in_label  (ram_rdata),
    .in_ctr    (p0_ctr),
    .out_valid (dist_valid),
    .out_label (dist_label),
    .out_dist  (dist_val),
    .busy      (dist_busy)
  );

endmodule

`default_nettype wire

### design/nlcs_ram.sv
// ----------------------------------------------------------------------------
// Nearest labeled cell search: generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module nlcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/nlcs_dist.sv
// ----------------------------------------------------------------------------
// Nearest labeled cell search: distance pipeline
// Four-stage saturating squared distance between the query point and a
// cell center, with the cell label carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module nlcs_dist #(
  parameter int LABEL_BITS = nlcs_pkg::LABEL_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  nlcs_pkg::coord_t            pt,
  input  logic                        in_valid,
  input  logic [LABEL_BITS-1:0]       in_label,
  input  nlcs_pkg::coord_t            in_ctr,
  output logic                        out_valid,
  output logic [LABEL_BITS-1:0]       out_label,
  output logic [nlcs_pkg::DIST_W-1:0] out_dist,
  output logic                        busy
);
  import nlcs_pkg::*;

  logic                  a_valid;
  logic                  b_valid;
  logic                  c_valid;
  logic [LABEL_BITS-1:0] a_label;
  logic [LABEL_BITS-1:0] b_label;
  logic [LABEL_BITS-1:0] c_label;
  coord_t                a_diff;
  logic [COORD_W-1:0]    abs_x;
  logic [COORD_W-1:0]    abs_y;
  logic [SQ_IN_W-1:0]    b_mag_x;
  logic [SQ_IN_W-1:0]    b_mag_y;
  logic                  b_sat_x;
  logic                  b_sat_y;
  logic [DIST_W-1:0]     c_sq_x;
  logic [DIST_W-1:0]     c_sq_y;
  logic [DIST_W:0]       sum;

  assign abs_x = a_diff.x[COORD_W-1] ? $unsigned(-a_diff.x) : $unsigned(a_diff.x);
  assign abs_y = a_diff.y[COORD_W-1] ? $unsigned(-a_diff.y) : $unsigned(a_diff.y);
  assign sum   = {1'b0, c_sq_x} + {1'b0, c_sq_y};
  assign busy  = a_valid | b_valid | c_valid | out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_label  <= in_label;
    a_diff.x <= pt.x - in_ctr.x;
    a_diff.y <= pt.y - in_ctr.y;

    b_label <= a_label;
    b_mag_x <= abs_x[SQ_IN_W-1:0];
    b_mag_y <= abs_y[SQ_IN_W-1:0];
    b_sat_x <= |abs_x[COORD_W-1:SQ_IN_W];
    b_sat_y <= |abs_y[COORD_W-1:SQ_IN_W];

    c_label <= b_label;
    c_sq_x  <= b_sat_x ? {DIST_W{1'b1}} : DIST_W'(b_mag_x) * DIST_W'(b_mag_x);
    c_sq_y  <= b_sat_y ? {DIST_W{1'b1}} : DIST_W'(b_mag_y) * DIST_W'(b_mag_y);

    out_label <= c_label;
    out_dist  <= sum[DIST_W] ? {DIST_W{1'b1}} : sum[DIST_W-1:0];
  end

endmodule

`default_nettype wire

### design/nlcs_checker.sv
// ----------------------------------------------------------------------------
// Nearest labeled cell search: port checker
// Watches the channel ports of the top level and binds to it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nearest_labeled_cell_search_defines.svh"

module nlcs_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       req_type,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] res_label,
  input logic       res_found
);

  // Reset starts the clearing pass and empties the result register.
  `NLCS_ASSERT_ALWAYS_NEXT(a_rst_no_result, clk, rst, !res_valid)
  `NLCS_ASSERT_ALWAYS_NEXT(a_rst_not_ready, clk, rst, !req_ready)

  // A query transfer starts a search, so no request is taken next cycle.
  `NLCS_ASSERT_NEXT(a_query_busy, clk, rst, req_valid && req_ready && req_type, !req_ready)

  // A result without a hit carries label zero.
  `NLCS_ASSERT_SAME(a_miss_label, clk, rst, res_valid && !res_found, res_label == 8'd0)

  `NLCS_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_label) && $stable(res_found))

endmodule

bind nearest_labeled_cell_search nlcs_checker u_nlcs_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_type  (req.req_type),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_label (res.nearest_label),
  .res_found (res.found)
);

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Nearest labeled cell search: testbench
// Loads label cells and sends point queries under random source gaps and sink
// stalls, across several raster sizes, cell sizes and origins written over the
// register port. Each query result is checked against a behavioral search
// that keeps its own raster copy and register shadow.
// ----------------------------------------------------------------------------

module testbench;
  import nlcs_pkg::*;

  typedef struct packed {
    logic [LABEL_FLD_W-1:0] nearest_label;
    logic                   found;
  } answer_t;

  typedef struct packed {
    logic                      req_type;
    logic [CELL_IDX_W-1:0]     cell_row;
    logic [CELL_IDX_W-1:0]     cell_col;
    logic [LABEL_FLD_W-1:0]    cell_label;
    logic signed [POINT_W-1:0] point_x;
    logic signed [POINT_W-1:0] point_y;
  } request_t;

  class nearest_cell_predictor;
    logic [LABEL_FLD_W-1:0] label_raster [MAX_ROWS_DEF * MAX_COLS_DEF];
    logic [DIM_W-1:0]       rows_in_use;
    logic [DIM_W-1:0]       cols_in_use;
    logic [EDGE_W-1:0]      cell_size;
    logic signed [31:0]     origin_x;
    logic signed [31:0]     origin_y;
    answer_t                pending_answers [$];
    int                     fault_count;

    function new();
      foreach (label_raster[i]) label_raster[i] = '0;
      rows_in_use = ROWS_RST;
      cols_in_use = COLS_RST;
      cell_size = EDGE_RST;
      origin_x = '0;
      origin_y = '0;
      fault_count = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        REG_ROWS_IN_USE: rows_in_use = value[DIM_W-1:0];
        REG_COLS_IN_USE: cols_in_use = value[DIM_W-1:0];
        REG_CELL_EDGE:   cell_size = value[EDGE_W-1:0];
        REG_ORIGIN_X:    origin_x = value;
        REG_ORIGIN_Y:    origin_y = value;
        default: ;
      endcase
    endfunction

    function longint unsigned square_sat(longint d);
      longint unsigned mag;
      mag = (d < 0) ? -d : d;
      if (mag > 64'hFFFF_FFFF) return '1;
      return mag * mag;
    endfunction

    function longint unsigned add_sat(longint unsigned a, longint unsigned b);
      logic [64:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[64] ? '1 : sum[63:0];
    endfunction

    function answer_t search_nearest(logic signed [POINT_W-1:0] px,
                                     logic signed [POINT_W-1:0] py);
      longint          px2, py2, side, bound2, cx2, cy2;
      longint unsigned best, sq_dist;
      int              nr, nc;
      answer_t         ans;
      nr = (rows_in_use > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows_in_use);
      nc = (cols_in_use > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cols_in_use);
      side = longint'(cell_size);
      px2 = 2 * longint'(px);
      py2 = 2 * longint'(py);
      bound2 = 2 * longint'(nr + nc) * side;
      best = square_sat(bound2);
      ans = '0;
      for (int r = 0; r < nr; r++) begin
        cy2 = 2 * longint'(origin_y) + 2 * longint'(nr - 1 - r) * side + side;
        for (int c = 0; c < nc; c++) begin
          if (label_raster[r * MAX_COLS_DEF + c] != '0) begin
            cx2 = 2 * longint'(origin_x) + 2 * longint'(c) * side + side;
            sq_dist = add_sat(square_sat(px2 - cx2), square_sat(py2 - cy2));
            if (sq_dist < best) begin
              best = sq_dist;
              ans.nearest_label = label_raster[r * MAX_COLS_DEF + c];
              ans.found = 1'b1;
            end
          end
        end
      end
      return ans;
    endfunction

    function void record_request(request_t rq);
      if (rq.req_type == REQ_QUERY) begin
        pending_answers.push_back(search_nearest(rq.point_x, rq.point_y));
      end else begin
        label_raster[int'(rq.cell_row) * MAX_COLS_DEF + int'(rq.cell_col)] = rq.cell_label;
      end
    endfunction

    function void note_fault(string text);
      fault_count++;
      if (fault_count <= 10) $display("mismatch: %s", text);
    endfunction

    function void check_answer(logic [LABEL_FLD_W-1:0] lbl, logic fnd);
      answer_t want;
      if (pending_answers.size() == 0) begin
        note_fault($sformatf("result with no query pending (label %0d found %0b)", lbl, fnd));
        return;
      end
      want = pending_answers.pop_front();
      if (lbl !== want.nearest_label)
        note_fault($sformatf("nearest_label expected %0d actual %0d", want.nearest_label, lbl));
      if (fnd !== want.found)
        note_fault($sformatf("found expected %0b actual %0b", want.found, fnd));
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  int                   burst_left;
  nearest_cell_predictor search_pred;

  nlcs_req_if req_bus ();
  nlcs_res_if res_bus ();

  nearest_labeled_cell_search dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_bus),
    .res     (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    search_pred.set_register(idx, value);
    @(posedge clk);
  endtask

  task automatic configure(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols,
                           input logic [EDGE_W-1:0] size,
                           input logic signed [31:0] ox, input logic signed [31:0] oy);
    write_register(REG_ROWS_IN_USE, 32'(rows));
    write_register(REG_COLS_IN_USE, 32'(cols));
    write_register(REG_CELL_EDGE, 32'(size));
    write_register(REG_ORIGIN_X, ox);
    write_register(REG_ORIGIN_Y, oy);
  endtask

  // Valid is lowered here and raised only on a later edge.
  task automatic drain_pause();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (search_pred.pending_answers.size() != 0);
    burst_left = 0;
  endtask

  task automatic wait_idle();
    drain_pause();
    repeat (20) @(posedge clk);
  endtask

  task automatic transfer_request(input request_t rq);
    if (burst_left == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 6);
    end
    burst_left--;
    req_bus.valid <= 1'b1;
    req_bus.req_type <= rq.req_type;
    req_bus.cell_row <= rq.cell_row;
    req_bus.cell_col <= rq.cell_col;
    req_bus.cell_label <= rq.cell_label;
    req_bus.point_x <= rq.point_x;
    req_bus.point_y <= rq.point_y;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    search_pred.record_request(rq);
  endtask

  task automatic send_write(input logic [7:0] row, input logic [7:0] col,
                            input logic [7:0] lbl);
    request_t rq;
    rq.req_type = REQ_WRITE;
    rq.cell_row = row;
    rq.cell_col = col;
    rq.cell_label = lbl;
    rq.point_x = $urandom;
    rq.point_y = $urandom;
    transfer_request(rq);
  endtask

  task automatic send_query(input logic signed [31:0] px, input logic signed [31:0] py);
    request_t rq;
    rq.req_type = REQ_QUERY;
    rq.cell_row = CELL_IDX_W'($urandom);
    rq.cell_col = CELL_IDX_W'($urandom);
    rq.cell_label = LABEL_FLD_W'($urandom);
    rq.point_x = px;
    rq.point_y = py;
    transfer_request(rq);
  endtask

  function automatic logic signed [31:0] near_coord(logic signed [31:0] base, int count);
    longint unsigned span;
    longint          off;
    span = longint'(count + 2) * longint'(search_pred.cell_size) + 1;
    off = longint'({$urandom, $urandom} % span) - longint'(search_pred.cell_size);
    return 32'(longint'(base) + off);
  endfunction

  function automatic logic signed [31:0] random_origin();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2, 3, 4: return $urandom;
      default: return 32'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] random_dim();
    case ($urandom_range(0, 9))
      0:       return DIM_W'($urandom_range(0, 2));
      1:       return DIM_W'($urandom_range(257, 511));
      default: return DIM_W'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [EDGE_W-1:0] random_size();
    case ($urandom_range(0, 7))
      4, 5:    return EDGE_W'($urandom);
      6:       return 24'hFF_FFFF;
      7:       return 24'd16;
      default: return EDGE_W'($urandom_range(1, 64));
    endcase
  endfunction

  initial begin
    logic [DIM_W-1:0]  rows, cols;
    int                nr, nc, count, sent;
    logic [7:0]        row, col, lbl;
    search_pred = new();
    burst_left = 0;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    req_bus.valid <= 1'b0;
    req_bus.req_type <= REQ_WRITE;
    req_bus.cell_row <= '0;
    req_bus.cell_col <= '0;
    req_bus.cell_label <= '0;
    req_bus.point_x <= '0;
    req_bus.point_y <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Full 256 by 256 raster at reset settings; these queries are slow.
    send_query(32'sd0, 32'sd0);
    send_write(8'd255, 8'd255, 8'hFF);
    send_write(8'd0, 8'd0, 8'h01);
    send_query(32'sd4088, 32'sd8);
    send_query(32'sh8000_0000, 32'sh7FFF_FFFF);

    // Small raster: a tie, an emptied cell, a point beyond the bound and a
    // cell outside the scanned rows.
    wait_idle();
    configure(9'd4, 9'd4, 24'd16, 32'sd0, 32'sd0);
    send_write(8'd0, 8'd1, 8'h22);
    send_query(32'sd16, 32'sd56);
    send_write(8'd0, 8'd0, 8'h00);
    send_query(32'sd16, 32'sd56);
    send_write(8'd3, 8'd3, 8'h80);
    send_query(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_write(8'd200, 8'd7, 8'h5A);
    send_query(32'sd120, 32'sd8);

    wait_idle();
    configure(9'd0, 9'd4, 24'd16, 32'sd0, 32'sd0);
    send_query(32'sd8, 32'sd8);
    wait_idle();
    configure(9'd300, 9'd0, 24'd16, 32'sd0, 32'sd0);
    send_query(32'sd8, 32'sd8);
    wait_idle();
    configure(9'd511, 9'd2, 24'd16, 32'sd0, 32'sd0);
    send_query(32'sd24, 32'sd4088);
    wait_idle();
    configure(9'd4, 9'd4, 24'd0, 32'sd0, 32'sd0);
    send_query(32'sd8, 32'sd56);

    // Largest cell at the coordinate extremes, where distances and the bound
    // saturate.
    wait_idle();
    configure(9'd300, 9'd2, 24'hFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_write(8'd255, 8'd1, 8'h3C);
    send_query(32'sh8180_0000, 32'sh7FFF_FFFF);
    send_query(32'sh7FFF_FFFF, 32'sh8000_0000);

    sent = 0;
    while (sent < 80) begin
      wait_idle();
      rows = random_dim();
      cols = random_dim();
      if (rows > 12 && cols > 12) cols = DIM_W'($urandom_range(1, 4));
      configure(rows, cols, random_size(), random_origin(), random_origin());
      nr = (rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows);
      nc = (cols > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cols);
      count = $urandom_range(8, 20);
      for (int k = 0; k < count; k++) begin
        if (k == count / 2 || $urandom_range(0, 15) == 0) drain_pause();
        if ($urandom_range(0, 1) == 0) begin
          if (nr > 0 && nc > 0 && $urandom_range(0, 6) != 0) begin
            row = 8'($urandom_range(0, nr - 1));
            col = 8'($urandom_range(0, nc - 1));
          end else begin
            row = 8'($urandom);
            col = 8'($urandom);
          end
          lbl = ($urandom_range(0, 6) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
          send_write(row, col, lbl);
        end else if ($urandom_range(0, 3) != 0) begin
          send_query(near_coord(search_pred.origin_x, nc), near_coord(search_pred.origin_y, nr));
        end else begin
          send_query($urandom, $urandom);
        end
        sent++;
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (search_pred.fault_count == 0 && search_pred.pending_answers.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    int mode, span;
    mode = 0;
    span = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
        search_pred.check_answer(res_bus.nearest_label, res_bus.found);
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(4, 40);
      end
      span--;
      case (mode)
        0:       res_bus.ready <= 1'b1;
        1:       res_bus.ready <= 1'($urandom_range(0, 1));
        2:       res_bus.ready <= (span % 4 == 0);
        default: res_bus.ready <= 1'b0;
      endcase
    end
  end

  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
